// ===== sv/mpi_pkg.sv =====
// ----------------------------------------------------------------------------
// mpi_pkg
// Shared constants and types of the multichannel PI regulator.
// ----------------------------------------------------------------------------
package mpi_pkg;

  localparam int DefChannels    = 6;
  localparam int DefPosChannels = 3;

  localparam int ChanW   = 3;
  localparam int SampleW = 24;
  localparam int DriveW  = 16;
  localparam int KpW     = 16;
  localparam int KiW     = 24;
  localparam int LimW    = 15;
  localparam int IntegW  = 32;

  localparam int ApbAddrW = 5;
  localparam int ApbDataW = 32;

  localparam logic [KpW-1:0]  PosKpReset     = 16'd5120;
  localparam logic [KiW-1:0]  PosKiDtReset   = 24'd10486;
  localparam logic [KpW-1:0]  SpeedKpReset   = 16'd256;
  localparam logic [KiW-1:0]  SpeedKiDtReset = 24'd1049;
  localparam logic [LimW-1:0] LimitReset     = 15'd1000;

  typedef enum logic [2:0] {
    RegPosKp       = 3'd0,
    RegPosKiDt     = 3'd1,
    RegSpeedKp     = 3'd2,
    RegSpeedKiDt   = 3'd3,
    RegOutputLimit = 3'd4
  } reg_idx_e;

endpackage

// ===== sv/mpi_if.sv =====
// ----------------------------------------------------------------------------
// mpi_if
// Valid/ready channels of the multichannel PI regulator.
// ----------------------------------------------------------------------------
interface mpi_in_if;
  import mpi_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [ChanW-1:0]          channel;
  logic signed [SampleW-1:0] setpoint;
  logic signed [SampleW-1:0] measurement;

  modport source (output valid, channel, setpoint, measurement, input ready);
  modport sink (input valid, channel, setpoint, measurement, output ready);
endinterface

interface mpi_out_if;
  import mpi_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [ChanW-1:0]         out_channel;
  logic signed [DriveW-1:0] drive;
  logic                     drive_clamped;

  modport source (output valid, out_channel, drive, drive_clamped, input ready);
  modport sink (input valid, out_channel, drive, drive_clamped, output ready);
endinterface

// ===== sv/multichannel_pi_controller.sv =====
// ----------------------------------------------------------------------------
// multichannel_pi_controller
// PI regulator for several channels with a clamped Q16.16 integral per channel.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle while the output accepts results
// and runs a five-stage pipeline: error and gain select with the integral
// memory read, the two gain multipliers, the integral increment scaling,
// the integral update and write-back, the sum, and the final truncation
// and limit into the output register. The integrals sit in
// one memory with a registered read port and one write port; an item whose
// channel is still being updated by an older item picks the new value up
// from the write-back path, so items of the same channel may follow each
// other in every cycle. A valid bit per channel, cleared at reset, makes
// every integral read as zero until it is first written, so no clearing
// pass is needed. Stages advance independently, so new items are taken
// while a result waits at the output until the pipeline is full.
// Configuration registers sit on an APB port at byte addresses 4*i.
module multichannel_pi_controller #(
  parameter int CHANNELS     = mpi_pkg::DefChannels,
  parameter int POS_CHANNELS = mpi_pkg::DefPosChannels
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  mpi_in_if.sink                        in_i,
  mpi_out_if.source                     out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mpi_pkg::ApbAddrW-1:0]  paddr,
  input  logic [mpi_pkg::ApbDataW-1:0]  pwdata,
  output logic [mpi_pkg::ApbDataW-1:0]  prdata,
  output logic                          pready
);
  import mpi_pkg::*;

  localparam int AddrW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [6:0] ChanLim = 7'(CHANNELS);
  localparam logic [6:0] PosLim  = 7'(POS_CHANNELS);

  logic [KpW-1:0]  pos_kp_q, speed_kp_q;
  logic [KiW-1:0]  pos_ki_dt_q, speed_ki_dt_q;
  logic [LimW-1:0] limit_q;

  logic signed [IntegW-1:0] mem_q [CHANNELS];
  logic [CHANNELS-1:0]      mem_vld_q;
  logic signed [IntegW-1:0] rd_data_q;
  logic                     rd_vld_q;

  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;
  logic acc;

  logic [ChanW-1:0] ch1_q, ch2_q, ch3_q, ch4_q, ch5_q;
  logic             inr1_q, inr2_q, inr3_q, inr4_q;

  logic signed [24:0]       err0, err1_q;
  logic [KpW-1:0]           kp0, kp1_q;
  logic [KiW-1:0]           ki0, ki1_q;
  logic                     inr0;
  logic [AddrW-1:0]         addr0;
  logic                     ovr1_q;
  logic signed [IntegW-1:0] ovr1_data_q, eff1;

  logic signed [48:0]       pi1, pi2_q, pib2;
  logic signed [40:0]       pp1, pp2_q, pp3_q, pp4_q;
  logic signed [IntegW-1:0] st2_q, st3_q;
  logic signed [44:0]       inc3_q;

  logic signed [45:0]       integ3, ilim3, integ4_q;
  logic signed [IntegW-1:0] wr_data;
  logic                     wr_en;
  logic [AddrW-1:0]         wr_addr;
  logic                     hit1, hit2, hit0;

  logic signed [49:0]       sum4;
  logic signed [33:0]       q5, qt5, lim5;
  logic signed [DriveW-1:0] drv5;
  logic                     clmp5;
  logic signed [DriveW-1:0] drive_q;
  logic                     clamped_q;

  function automatic logic [AddrW-1:0] ch_addr(input logic [ChanW-1:0] ch, input logic inr);
    logic [AddrW+ChanW-1:0] wide;
    wide = {{AddrW{1'b0}}, ch};
    ch_addr = inr ? wide[AddrW-1:0] : '0;
  endfunction

  // Configuration port.
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_kp_q      <= PosKpReset;
      pos_ki_dt_q   <= PosKiDtReset;
      speed_kp_q    <= SpeedKpReset;
      speed_ki_dt_q <= SpeedKiDtReset;
      limit_q       <= LimitReset;
    end else if (psel && penable && pwrite) begin
      case (reg_idx_e'(paddr[4:2]))
        RegPosKp:       pos_kp_q      <= pwdata[KpW-1:0];
        RegPosKiDt:     pos_ki_dt_q   <= pwdata[KiW-1:0];
        RegSpeedKp:     speed_kp_q    <= pwdata[KpW-1:0];
        RegSpeedKiDt:   speed_ki_dt_q <= pwdata[KiW-1:0];
        RegOutputLimit: limit_q       <= pwdata[LimW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_e'(paddr[4:2]))
      RegPosKp:       prdata = {16'd0, pos_kp_q};
      RegPosKiDt:     prdata = {8'd0, pos_ki_dt_q};
      RegSpeedKp:     prdata = {16'd0, speed_kp_q};
      RegSpeedKiDt:   prdata = {8'd0, speed_ki_dt_q};
      RegOutputLimit: prdata = {17'd0, limit_q};
      default:        prdata = '0;
    endcase
  end

  // Pipeline flow control.
  assign rdy5 = !v5_q || out_o.ready;
  assign rdy4 = !v4_q || rdy5;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign in_i.ready = rdy1;
  assign acc = in_i.valid && rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_i.valid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
      if (rdy5) v5_q <= v4_q;
    end
  end

  // Stage 0: error, gain select and integral read.
  assign err0  = {in_i.setpoint[SampleW-1], in_i.setpoint}
               - {in_i.measurement[SampleW-1], in_i.measurement};
  assign inr0  = {4'd0, in_i.channel} < ChanLim;
  assign kp0   = ({4'd0, in_i.channel} < PosLim) ? pos_kp_q : speed_kp_q;
  assign ki0   = ({4'd0, in_i.channel} < PosLim) ? pos_ki_dt_q : speed_ki_dt_q;
  assign addr0 = ch_addr(in_i.channel, inr0);

  // Write-back of stage 3 and forwarding to younger items.
  assign wr_en   = v3_q && rdy4 && inr3_q;
  assign wr_addr = ch_addr(ch3_q, inr3_q);
  assign hit0    = wr_en && (in_i.channel == ch3_q);
  assign hit1    = wr_en && (ch1_q == ch3_q);
  assign hit2    = wr_en && (ch2_q == ch3_q);
  assign eff1    = ovr1_q ? ovr1_data_q : (rd_vld_q ? rd_data_q : '0);

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
    if (acc) rd_data_q <= mem_q[addr0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mem_vld_q <= '0;
      rd_vld_q  <= 1'b0;
      ovr1_q    <= 1'b0;
    end else begin
      if (wr_en) mem_vld_q[wr_addr] <= 1'b1;
      if (acc) begin
        rd_vld_q <= mem_vld_q[addr0];
        ovr1_q   <= hit0;
      end else if (hit1) begin
        ovr1_q <= 1'b1;
      end
    end
  end

  // Stage 1: gain multipliers.
  assign pi1 = err1_q * $signed({1'b0, ki1_q});
  assign pp1 = err1_q * $signed({1'b0, kp1_q});

  // Stage 2: increment scaled to Q16.16 with truncation toward zero.
  assign pib2 = pi2_q + (pi2_q[48] ? 49'sd15 : 49'sd0);

  // Stage 3: integral update and clamp.
  assign integ3  = $signed({{14{st3_q[IntegW-1]}}, st3_q}) + $signed({inc3_q[44], inc3_q});
  assign ilim3   = $signed({15'd0, limit_q, 16'd0});

  always_comb begin
    if (integ3 > ilim3) begin
      wr_data = ilim3[IntegW-1:0];
    end else if (integ3 < -ilim3) begin
      wr_data = 32'(-ilim3);
    end else begin
      wr_data = integ3[IntegW-1:0];
    end
  end

  // Stage 4: proportional term plus integral, truncation toward zero and
  // output limit.
  assign sum4 = $signed({pp4_q[40], pp4_q, 8'd0}) + $signed({{4{integ4_q[45]}}, integ4_q});

  assign q5   = sum4[49:16];
  assign qt5  = q5 + ((sum4[49] && (|sum4[15:0])) ? 34'sd1 : 34'sd0);
  assign lim5 = $signed({19'd0, limit_q});

  always_comb begin
    if (!inr4_q) begin
      drv5  = '0;
      clmp5 = 1'b0;
    end else if (qt5 > lim5) begin
      drv5  = lim5[DriveW-1:0];
      clmp5 = 1'b1;
    end else if (qt5 < -lim5) begin
      drv5  = 16'(-lim5);
      clmp5 = 1'b1;
    end else begin
      drv5  = qt5[DriveW-1:0];
      clmp5 = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      ch1_q       <= in_i.channel;
      inr1_q      <= inr0;
      err1_q      <= err0;
      kp1_q       <= kp0;
      ki1_q       <= ki0;
      ovr1_data_q <= wr_data;
    end else if (hit1) begin
      ovr1_data_q <= wr_data;
    end
    if (rdy2) begin
      ch2_q  <= ch1_q;
      inr2_q <= inr1_q;
      pi2_q  <= pi1;
      pp2_q  <= pp1;
      st2_q  <= hit1 ? wr_data : eff1;
    end else if (hit2) begin
      st2_q <= wr_data;
    end
    if (rdy3) begin
      ch3_q  <= ch2_q;
      inr3_q <= inr2_q;
      inc3_q <= pib2[48:4];
      pp3_q  <= pp2_q;
      st3_q  <= hit2 ? wr_data : st2_q;
    end
    if (rdy4) begin
      ch4_q    <= ch3_q;
      inr4_q   <= inr3_q;
      pp4_q    <= pp3_q;
      integ4_q <= integ3;
    end
    if (rdy5) begin
      ch5_q     <= ch4_q;
      drive_q   <= drv5;
      clamped_q <= clmp5;
    end
  end

  assign out_o.valid         = v5_q;
  assign out_o.out_channel   = ch5_q;
  assign out_o.drive         = drive_q;
  assign out_o.drive_clamped = clamped_q;

endmodule
